// ===== src/ray_triangle_intersect_unit_assert.svh =====
// Assertion macros for the ray/triangle intersection unit.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RTI_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rti assertion failed");

// Next-cycle implication, checked out of reset.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rti assertion failed");

`endif

// ===== src/rti_pkg.sv =====
// Shared types and constants of the ray/triangle intersection unit.
// No dependencies.
`default_nettype none

package rti_pkg;

	localparam int unsigned CW    = 16;          // coordinate width
	localparam int unsigned PACKW = 48;          // packed vector register width
	localparam int unsigned EPSW  = 16;          // epsilon register width
	localparam int unsigned TW    = CW + 1;      // origin minus vertex
	localparam int unsigned PRW   = 2 * CW;      // product for the p vector
	localparam int unsigned PW    = PRW + 1;     // p vector
	localparam int unsigned QPW   = TW + CW;     // product for the q vector
	localparam int unsigned QW    = QPW + 1;     // q vector
	localparam int unsigned DPW   = CW + PW;     // determinant product
	localparam int unsigned DW    = DPW + 2;     // determinant
	localparam int unsigned NPW   = TW + PW;     // numerator product
	localparam int unsigned NW    = NPW + 2;     // numerators
	localparam int unsigned DMW   = DW;          // determinant magnitude
	localparam int unsigned RW    = DMW + 1;     // divider remainder
	localparam int unsigned FB    = 16;          // result fraction bits
	localparam int unsigned TQW   = 31;          // distance quotient bits
	localparam int unsigned TSAT  = TQW - FB;    // integer bits of distance
	localparam int unsigned UVQ   = FB;          // barycentric quotient bits
	localparam int unsigned UVW   = FB + 1;      // barycentric output width
	localparam int unsigned DISTW = 32;
	localparam int unsigned GEOM_STAGES = 7;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned IDX_W  = 3;

	localparam logic [DISTW-1:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [DISTW-1:0] DIST_MIN = 32'h8000_0000;
	localparam logic [UVW-1:0]   UV_ONE   = 17'h1_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_CULLING = 3'd0,
		REG_VERTEX  = 3'd1,
		REG_EDGE1   = 3'd2,
		REG_EDGE2   = 3'd3,
		REG_EPSILON = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] ray_start_x;
		logic signed [CW-1:0] ray_start_y;
		logic signed [CW-1:0] ray_start_z;
		logic signed [CW-1:0] ray_dir_x;
		logic signed [CW-1:0] ray_dir_y;
		logic signed [CW-1:0] ray_dir_z;
	} ray_t;

	typedef struct packed {
		logic                    is_hit;
		logic signed [DISTW-1:0] hit_distance;
		logic [UVW-1:0]          bary_u;
		logic [UVW-1:0]          bary_v;
	} res_t;

	typedef struct packed {
		logic             culling_enabled;
		logic [PACKW-1:0] vertex_base;
		logic [PACKW-1:0] edge_one;
		logic [PACKW-1:0] edge_two;
		logic [EPSW-1:0]  det_epsilon;
	} cfg_t;

	typedef struct packed {
		logic           hit;
		logic           neg;
		logic           sat;
		logic           fu;
		logic           fv;
		logic [DMW-1:0] det;
		logic [RW-1:0]  rt;
		logic [TQW-1:0] qt;
		logic [TQW-1:0] pend;
		logic [RW-1:0]  ru;
		logic [UVQ-1:0] qu;
		logic [RW-1:0]  rv;
		logic [UVQ-1:0] qv;
	} div_t;

endpackage

`default_nettype wire

// ===== src/rti_ifs.sv =====
// Valid/ready channel interfaces for rays in and results out.
// Depends on rti_pkg.
`default_nettype none

interface rti_ray_if;
	logic          valid;
	logic          ready;
	rti_pkg::ray_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rti_res_if;
	logic          valid;
	logic          ready;
	rti_pkg::res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/rti_cfg_regs.sv =====
// APB-style configuration registers of the intersection unit.
// Depends on rti_pkg.
`default_nettype none

module rti_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rti_pkg::ADDR_W-1:0] paddr,
	input  logic [rti_pkg::DATA_W-1:0] pwdata,
	output logic [rti_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rti_pkg::cfg_t              cfg
);

	rti_pkg::cfg_t           cfg_q;
	logic [rti_pkg::IDX_W-1:0] idx;
	logic                    wr;

	assign idx    = paddr[rti_pkg::ADDR_W-1:rti_pkg::ADDR_W-rti_pkg::IDX_W];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.culling_enabled <= 1'b1;
			cfg_q.vertex_base     <= '0;
			cfg_q.edge_one        <= '0;
			cfg_q.edge_two        <= '0;
			cfg_q.det_epsilon     <= rti_pkg::EPSW'(1);
		end else if (wr) begin
			unique case (idx)
				rti_pkg::REG_CULLING: cfg_q.culling_enabled <= pwdata[0];
				rti_pkg::REG_VERTEX:  cfg_q.vertex_base <= pwdata[rti_pkg::PACKW-1:0];
				rti_pkg::REG_EDGE1:   cfg_q.edge_one <= pwdata[rti_pkg::PACKW-1:0];
				rti_pkg::REG_EDGE2:   cfg_q.edge_two <= pwdata[rti_pkg::PACKW-1:0];
				rti_pkg::REG_EPSILON: cfg_q.det_epsilon <= pwdata[rti_pkg::EPSW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rti_pkg::REG_CULLING: prdata = rti_pkg::DATA_W'(cfg_q.culling_enabled);
			rti_pkg::REG_VERTEX:  prdata = rti_pkg::DATA_W'(cfg_q.vertex_base);
			rti_pkg::REG_EDGE1:   prdata = rti_pkg::DATA_W'(cfg_q.edge_one);
			rti_pkg::REG_EDGE2:   prdata = rti_pkg::DATA_W'(cfg_q.edge_two);
			rti_pkg::REG_EPSILON: prdata = rti_pkg::DATA_W'(cfg_q.det_epsilon);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/rti_geom.sv =====
// Seven-stage geometry pipeline: cross and dot products, determinant tests,
// sign folding and divider setup. Depends on rti_pkg.
`default_nettype none

module rti_geom (
	input  logic          clk,
	input  logic          en,
	input  rti_pkg::ray_t ray,
	input  rti_pkg::cfg_t cfg,
	output rti_pkg::div_t div_out
);

	localparam int unsigned CW   = rti_pkg::CW;
	localparam int unsigned TW   = rti_pkg::TW;
	localparam int unsigned PRW  = rti_pkg::PRW;
	localparam int unsigned PW   = rti_pkg::PW;
	localparam int unsigned QPW  = rti_pkg::QPW;
	localparam int unsigned QW   = rti_pkg::QW;
	localparam int unsigned DPW  = rti_pkg::DPW;
	localparam int unsigned DW   = rti_pkg::DW;
	localparam int unsigned NPW  = rti_pkg::NPW;
	localparam int unsigned NW   = rti_pkg::NW;
	localparam int unsigned DMW  = rti_pkg::DMW;
	localparam int unsigned RW   = rti_pkg::RW;
	localparam int unsigned TSAT = rti_pkg::TSAT;
	localparam int unsigned EPSW = rti_pkg::EPSW;
	localparam int unsigned UVQ  = rti_pkg::UVQ;

	logic signed [CW-1:0] org [3];
	logic signed [CW-1:0] dir [3];
	logic signed [CW-1:0] v0 [3];
	logic signed [CW-1:0] e1 [3];
	logic signed [CW-1:0] e2 [3];

	always_comb begin
		org[0] = ray.ray_start_x;
		org[1] = ray.ray_start_y;
		org[2] = ray.ray_start_z;
		dir[0] = ray.ray_dir_x;
		dir[1] = ray.ray_dir_y;
		dir[2] = ray.ray_dir_z;
		v0[0]  = cfg.vertex_base[CW-1:0];
		v0[1]  = cfg.vertex_base[2*CW-1:CW];
		v0[2]  = cfg.vertex_base[3*CW-1:2*CW];
		e1[0]  = cfg.edge_one[CW-1:0];
		e1[1]  = cfg.edge_one[2*CW-1:CW];
		e1[2]  = cfg.edge_one[3*CW-1:2*CW];
		e2[0]  = cfg.edge_two[CW-1:0];
		e2[1]  = cfg.edge_two[2*CW-1:CW];
		e2[2]  = cfg.edge_two[3*CW-1:2*CW];
	end

	// stage 1: products of dir x e2, origin offset
	logic signed [PRW-1:0] pa_s1 [3];
	logic signed [PRW-1:0] pb_s1 [3];
	logic signed [TW-1:0]  tv_s1 [3];
	logic signed [CW-1:0]  dir_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= dir[1] * e2[2];
			pb_s1[0] <= dir[2] * e2[1];
			pa_s1[1] <= dir[2] * e2[0];
			pb_s1[1] <= dir[0] * e2[2];
			pa_s1[2] <= dir[0] * e2[1];
			pb_s1[2] <= dir[1] * e2[0];
			for (int k = 0; k < 3; k++) begin
				tv_s1[k]  <= org[k] - v0[k];
				dir_s1[k] <= dir[k];
			end
		end
	end

	// stage 2: p vector, products of tv x e1
	logic signed [PW-1:0]  pv_s2 [3];
	logic signed [QPW-1:0] qa_s2 [3];
	logic signed [QPW-1:0] qb_s2 [3];
	logic signed [TW-1:0]  tv_s2 [3];
	logic signed [CW-1:0]  dir_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s2[0] <= tv_s1[1] * e1[2];
			qb_s2[0] <= tv_s1[2] * e1[1];
			qa_s2[1] <= tv_s1[2] * e1[0];
			qb_s2[1] <= tv_s1[0] * e1[2];
			qa_s2[2] <= tv_s1[0] * e1[1];
			qb_s2[2] <= tv_s1[1] * e1[0];
			for (int k = 0; k < 3; k++) begin
				pv_s2[k]  <= pa_s1[k] - pb_s1[k];
				tv_s2[k]  <= tv_s1[k];
				dir_s2[k] <= dir_s1[k];
			end
		end
	end

	// stage 3: q vector, determinant and u products
	logic signed [QW-1:0]  qv_s3 [3];
	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [NPW-1:0] up_s3 [3];
	logic signed [CW-1:0]  dir_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				qv_s3[k]  <= qa_s2[k] - qb_s2[k];
				dp_s3[k]  <= e1[k] * pv_s2[k];
				up_s3[k]  <= tv_s2[k] * pv_s2[k];
				dir_s3[k] <= dir_s2[k];
			end
		end
	end

	// stage 4: determinant and u sums, v and t products
	logic signed [DW-1:0]  det_s4;
	logic signed [NW-1:0]  nu_s4;
	logic signed [NPW-1:0] vp_s4 [3];
	logic signed [NPW-1:0] tp_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= dp_s3[0] + dp_s3[1] + dp_s3[2];
			nu_s4  <= up_s3[0] + up_s3[1] + up_s3[2];
			for (int k = 0; k < 3; k++) begin
				vp_s4[k] <= dir_s3[k] * qv_s3[k];
				tp_s4[k] <= e2[k] * qv_s3[k];
			end
		end
	end

	// stage 5: v and t sums, determinant acceptance
	logic signed [EPSW:0]  eps_s;
	logic signed [DW-1:0]  det_abs;
	logic                  det_ok;
	logic signed [DW-1:0]  det_s5;
	logic signed [NW-1:0]  nu_s5;
	logic signed [NW-1:0]  nv_s5;
	logic signed [NW-1:0]  nt_s5;
	logic                  ok_s5;

	always_comb begin
		eps_s   = {1'b0, cfg.det_epsilon};
		det_abs = det_s4[DW-1] ? -det_s4 : det_s4;
		if (cfg.culling_enabled) begin
			det_ok = (det_s4 != '0) && !(det_s4 < eps_s);
		end else begin
			det_ok = (det_s4 != '0) && !(det_abs < eps_s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= det_s4;
			nu_s5  <= nu_s4;
			nv_s5  <= vp_s4[0] + vp_s4[1] + vp_s4[2];
			nt_s5  <= tp_s4[0] + tp_s4[1] + tp_s4[2];
			ok_s5  <= det_ok;
		end
	end

	// stage 6: fold a negative determinant into the numerators
	logic signed [DW-1:0] det_s6;
	logic signed [NW-1:0] nu_s6;
	logic signed [NW-1:0] nv_s6;
	logic signed [NW-1:0] nt_s6;
	logic                 ok_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s6 <= ok_s5;
			if (det_s5[DW-1]) begin
				det_s6 <= -det_s5;
				nu_s6  <= -nu_s5;
				nv_s6  <= -nv_s5;
				nt_s6  <= -nt_s5;
			end else begin
				det_s6 <= det_s5;
				nu_s6  <= nu_s5;
				nv_s6  <= nv_s5;
				nt_s6  <= nt_s5;
			end
		end
	end

	// stage 7: edge tests, distance saturation, divider start values
	logic signed [NW:0]        uv_sum;
	logic                      in_tri;
	logic [NW-1:0]             nt_mag;
	logic [DMW-1:0]            det_m;
	logic [DMW+TSAT-1:0]       det_sh;
	rti_pkg::div_t             nxt;

	always_comb begin
		uv_sum = nu_s6 + nv_s6;
		in_tri = !nu_s6[NW-1] && !(nu_s6 > det_s6) && !nv_s6[NW-1] && !(uv_sum > det_s6);
		nt_mag = nt_s6[NW-1] ? -nt_s6 : nt_s6;
		det_m  = det_s6[DMW-1:0];
		det_sh = {det_m, {TSAT{1'b0}}};
		nxt.hit  = ok_s6 && in_tri;
		nxt.neg  = nt_s6[NW-1];
		nxt.sat  = (DMW+TSAT)'(nt_mag) >= det_sh;
		nxt.fu   = nu_s6 >= det_s6;
		nxt.fv   = nv_s6 >= det_s6;
		nxt.det  = det_m;
		nxt.rt   = RW'(nt_mag[NW-1:TSAT]);
		nxt.qt   = '0;
		nxt.pend = {nt_mag[TSAT-1:0], {UVQ{1'b0}}};
		nxt.ru   = nu_s6[RW-1:0];
		nxt.qu   = '0;
		nxt.rv   = nv_s6[RW-1:0];
		nxt.qv   = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_out <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/rti_div_stage.sv =====
// One restoring-division step for distance, u and v (u and v stop after
// their last fraction bit). Depends on rti_pkg.
`default_nettype none

module rti_div_stage #(
	parameter int unsigned STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  rti_pkg::div_t d_in,
	output rti_pkg::div_t d_out
);

	localparam int unsigned RW  = rti_pkg::RW;
	localparam int unsigned DMW = rti_pkg::DMW;
	localparam int unsigned TQW = rti_pkg::TQW;
	localparam int unsigned UVQ = rti_pkg::UVQ;

	function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic b,
			input logic [DMW-1:0] den);
		logic [RW-1:0] rs;
		logic [RW-1:0] dz;
		rs = {r[RW-2:0], b};
		dz = RW'(den);
		if (rs >= dz) begin
			return {1'b1, rs - dz};
		end
		return {1'b0, rs};
	endfunction

	logic [RW:0]   st;
	logic [RW:0]   su;
	logic [RW:0]   sv;
	rti_pkg::div_t nxt;

	always_comb begin
		nxt  = d_in;
		st   = div_step(d_in.rt, d_in.pend[TQW-1], d_in.det);
		su   = div_step(d_in.ru, 1'b0, d_in.det);
		sv   = div_step(d_in.rv, 1'b0, d_in.det);
		nxt.rt   = st[RW-1:0];
		nxt.qt   = {d_in.qt[TQW-2:0], st[RW]};
		nxt.pend = {d_in.pend[TQW-2:0], 1'b0};
		if (STEP < UVQ) begin
			nxt.ru = su[RW-1:0];
			nxt.qu = {d_in.qu[UVQ-2:0], su[RW]};
			nxt.rv = sv[RW-1:0];
			nxt.qv = {d_in.qv[UVQ-2:0], sv[RW]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/ray_triangle_intersect_unit.sv =====
// Top level of the ray/triangle intersection unit (Moller-Trumbore).
// Depends on rti_pkg, rti_ifs, rti_cfg_regs, rti_geom, rti_div_stage.
//
// Usage:
//  - Program the triangle over the APB port while no ray is in flight:
//    culling flag, first vertex, both edges and the determinant epsilon,
//    at byte addresses 0, 8, 16, 24 and 32. pready is always high.
//  - Rays enter on the ray channel, one transfer per cycle at most; each
//    result leaves on the res channel in the same order.
//  - Pipeline: a ray passes 39 register stages on its way to res
//    (7 geometry, 31 divider, output register).
//  - Throughput: one ray per cycle while the skid register is empty;
//    the 31-step distance divider is unrolled into stages, so nothing
//    in the datapath iterates.
//  - Stall: while res is held off the pipeline keeps advancing until an
//    item leaves the last stage; that item parks in a skid register, and
//    the whole pipeline and ray.ready hold only while the skid is full.
//  - Reset clears all valid bits and loads the register defaults
//    (culling on, triangle zero, epsilon one).
`default_nettype none

module ray_triangle_intersect_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	rti_ray_if.sink                    ray,
	rti_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rti_pkg::ADDR_W-1:0] paddr,
	input  logic [rti_pkg::DATA_W-1:0] pwdata,
	output logic [rti_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int unsigned NP  = rti_pkg::GEOM_STAGES + rti_pkg::TQW;
	localparam int unsigned TQW = rti_pkg::TQW;

	rti_pkg::cfg_t cfg;

	rti_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// global advance: the whole pipeline moves unless the skid slot is taken
	logic          en;
	logic [NP-1:0] stage_vld_q;
	logic          skid_vld_q;
	rti_pkg::res_t skid_q;
	logic          out_vld_q;
	rti_pkg::res_t out_q;

	assign en        = !skid_vld_q;
	assign ray.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[NP-2:0], ray.valid};
		end
	end

	rti_pkg::div_t dchain [TQW+1];

	rti_geom u_geom (
		.clk     (clk),
		.en      (en),
		.ray     (ray.payload),
		.cfg     (cfg),
		.div_out (dchain[0])
	);

	for (genvar g = 0; g < TQW; g++) begin : g_div
		rti_div_stage #(
			.STEP (g)
		) u_div (
			.clk   (clk),
			.en    (en),
			.d_in  (dchain[g]),
			.d_out (dchain[g+1])
		);
	end

	// pack the last stage into a result; a miss gives all zeros
	rti_pkg::div_t            last;
	rti_pkg::res_t            fmt;
	logic [rti_pkg::DISTW-1:0] tq;

	always_comb begin
		last = dchain[TQW];
		tq   = rti_pkg::DISTW'(last.qt);
		fmt  = '0;
		if (last.hit) begin
			fmt.is_hit = 1'b1;
			if (last.sat) begin
				fmt.hit_distance = last.neg ? rti_pkg::DIST_MIN : rti_pkg::DIST_MAX;
			end else begin
				fmt.hit_distance = last.neg ? -tq : tq;
			end
			fmt.bary_u = last.fu ? rti_pkg::UV_ONE : rti_pkg::UVW'(last.qu);
			fmt.bary_v = last.fv ? rti_pkg::UV_ONE : rti_pkg::UVW'(last.qv);
		end
	end

	logic incoming;
	assign incoming = en && stage_vld_q[NP-1];

	// output register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !res.ready) begin
			// hold the result; park the item leaving the pipeline
			if (incoming) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= incoming;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !res.ready) begin
			if (incoming) begin
				skid_q <= fmt;
			end
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else if (incoming) begin
			out_q <= fmt;
		end
	end

	assign res.valid   = out_vld_q;
	assign res.payload = out_q;

endmodule

`default_nettype wire

// ===== src/rti_checker.sv =====
// Port-level checks of the intersection unit, bound to its top level.
// Depends on ray_triangle_intersect_unit_assert.svh.
`default_nettype none
`include "ray_triangle_intersect_unit_assert.svh"

module rti_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        ray_ready,
	input wire        res_valid,
	input wire        res_ready,
	input wire        res_is_hit,
	input wire [31:0] res_dist,
	input wire [16:0] res_u,
	input wire [16:0] res_v
);

	// a stalled result stays up
	`RTI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

	// input backpressure only comes from a waiting result
	`RTI_ASSERT_IMPLY(a_bp_source, !ray_ready, res_valid)

	// a miss carries no distance and no barycentrics
	`RTI_ASSERT_IMPLY(a_miss_zero, res_valid && !res_is_hit, res_dist == 32'd0 && res_u == 17'd0 && res_v == 17'd0)

	// barycentrics of a hit stay within the triangle
	`RTI_ASSERT_IMPLY(a_bary_sum, res_valid && res_is_hit, ({1'b0, res_u} + {1'b0, res_v}) <= 18'd65536)

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.ray_ready  (ray.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_is_hit (res.payload.is_hit),
	.res_dist   (res.payload.hit_distance),
	.res_u      (res.payload.bary_u),
	.res_v      (res.payload.bary_v)
);

`default_nettype wire
